// File: rtl/core/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg: shared types and widths for the point-in-triangle test
// Coordinate width and the derived widths of differences, cross products,
// split partial products and dot sums.
// ----------------------------------------------------------------------------
package pit_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int CROSS_W    = 2 * DIFF_W + 1;
  // normal components are split in two halves for the dot multipliers
  localparam int LO_W       = (CROSS_W + 1) / 2;
  localparam int HI_W       = CROSS_W - LO_W;
  localparam int PLO_W      = CROSS_W + LO_W + 1;
  localparam int PHI_W      = CROSS_W + HI_W;
  localparam int PROD_W     = 2 * CROSS_W;
  localparam int DOT_W      = PROD_W + 2;
  localparam int NSTAGE     = 5;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [CROSS_W-1:0]    cross_t;
  typedef logic signed [PLO_W-1:0]      plo_t;
  typedef logic signed [PHI_W-1:0]      phi_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [DOT_W-1:0]      dot_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  // stage load enables, front half
  typedef struct packed {
    logic s1;
    logic s2;
  } pit_cross_en_t;

  // stage load enables, back half
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
  } pit_dot_en_t;

endpackage

// File: rtl/core/pit_cross.sv
// ----------------------------------------------------------------------------
// pit_cross: edge vectors and cross products
// Stage 1 registers the edge and point-offset vectors, stage 2 the triangle
// normal and the cross product of each edge with its point offset.
// ----------------------------------------------------------------------------
module pit_cross (
  input  logic                  clk,
  input  pit_pkg::pit_cross_en_t en,
  input  pit_pkg::point_t       pt_a,
  input  pit_pkg::point_t       pt_b,
  input  pit_pkg::point_t       pt_c,
  input  pit_pkg::point_t       pt_p,
  output pit_pkg::cross_t       n_o [3],
  output pit_pkg::cross_t       c_o [3][3]
);

  pit_pkg::coord_t v [4][3];
  pit_pkg::diff_t  edge_nxt [3][3];
  pit_pkg::diff_t  toff_nxt [3][3];
  pit_pkg::diff_t  edge_r   [3][3];
  pit_pkg::diff_t  toff_r   [3][3];
  pit_pkg::cross_t n_r [3];
  pit_pkg::cross_t c_r [3][3];

  // a*b - c*d at full precision
  function automatic pit_pkg::cross_t xterm(pit_pkg::diff_t a, pit_pkg::diff_t b,
                                            pit_pkg::diff_t c, pit_pkg::diff_t d);
    logic signed [2*pit_pkg::DIFF_W-1:0] p;
    logic signed [2*pit_pkg::DIFF_W-1:0] q;
    p = a * b;
    q = c * d;
    return pit_pkg::cross_t'(p) - pit_pkg::cross_t'(q);
  endfunction

  assign v[0] = '{pt_a.x, pt_a.y, pt_a.z};
  assign v[1] = '{pt_b.x, pt_b.y, pt_b.z};
  assign v[2] = '{pt_c.x, pt_c.y, pt_c.z};
  assign v[3] = '{pt_p.x, pt_p.y, pt_p.z};

  // edge k runs from vertex k to vertex k+1 (mod 3): AB, BC, CA
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        edge_nxt[k][j] = pit_pkg::diff_t'(v[(k + 1) % 3][j]) - pit_pkg::diff_t'(v[k][j]);
        toff_nxt[k][j] = pit_pkg::diff_t'(v[3][j]) - pit_pkg::diff_t'(v[k][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      edge_r <= edge_nxt;
      toff_r <= toff_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      // normal = AB x BC
      n_r[0] <= xterm(edge_r[0][1], edge_r[1][2], edge_r[0][2], edge_r[1][1]);
      n_r[1] <= xterm(edge_r[0][2], edge_r[1][0], edge_r[0][0], edge_r[1][2]);
      n_r[2] <= xterm(edge_r[0][0], edge_r[1][1], edge_r[0][1], edge_r[1][0]);
      for (int k = 0; k < 3; k++) begin
        c_r[k][0] <= xterm(edge_r[k][1], toff_r[k][2], edge_r[k][2], toff_r[k][1]);
        c_r[k][1] <= xterm(edge_r[k][2], toff_r[k][0], edge_r[k][0], toff_r[k][2]);
        c_r[k][2] <= xterm(edge_r[k][0], toff_r[k][1], edge_r[k][1], toff_r[k][0]);
      end
    end
  end

  assign n_o = n_r;
  assign c_o = c_r;

endmodule

// File: rtl/core/pit_dot.sv
// ----------------------------------------------------------------------------
// pit_dot: dot products against the normal and the inside decision
// Stage 3 forms split partial products, stage 4 recombines them, stage 5
// sums each dot, tests the signs and holds the result.
// ----------------------------------------------------------------------------
module pit_dot (
  input  logic                clk,
  input  pit_pkg::pit_dot_en_t en,
  input  pit_pkg::cross_t     n_i [3],
  input  pit_pkg::cross_t     c_i [3][3],
  output logic                inside_o
);

  logic signed [pit_pkg::LO_W:0]   n_lo [3];
  logic signed [pit_pkg::HI_W-1:0] n_hi [3];
  pit_pkg::plo_t  plo_r  [3][3];
  pit_pkg::phi_t  phi_r  [3][3];
  pit_pkg::prod_t prod_r [3][3];
  pit_pkg::dot_t  dot    [3];
  logic           inside_nxt;
  logic           inside_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      n_lo[j] = $signed({1'b0, n_i[j][pit_pkg::LO_W-1:0]});
      n_hi[j] = n_i[j][pit_pkg::CROSS_W-1:pit_pkg::LO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          plo_r[k][j] <= c_i[k][j] * n_lo[j];
          phi_r[k][j] <= c_i[k][j] * n_hi[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[k][j] <= (pit_pkg::prod_t'(phi_r[k][j]) <<< pit_pkg::LO_W)
                          + pit_pkg::prod_t'(plo_r[k][j]);
        end
      end
    end
  end

  // zero dots count as inside
  always_comb begin
    inside_nxt = 1'b1;
    for (int k = 0; k < 3; k++) begin
      dot[k] = pit_pkg::dot_t'(prod_r[k][0]) + pit_pkg::dot_t'(prod_r[k][1])
             + pit_pkg::dot_t'(prod_r[k][2]);
      if (dot[k][pit_pkg::DOT_W-1]) begin
        inside_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      inside_r <= inside_nxt;
    end
  end

  assign inside_o = inside_r;

endmodule

// File: rtl/core/point_in_triangle_test.sv
// ----------------------------------------------------------------------------
// point_in_triangle_test: same-side point-in-triangle test, pipelined
// Reports whether a 3D query point lies inside triangle ABC.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one word: vertices A, B, C and
//   query point P, each coordinate a signed fixed-point value (shared scale).
//   Output channel out_valid/out_ready carries out_inside_res: 1 when no edge
//   dot against the normal AB x BC is negative (on-edge and degenerate
//   triangles report inside), else 0. One result per input word, in order.
//   Throughput: one word per cycle while out_ready stays high. The datapath
//   is five register stages: edge vectors, cross products, split partial
//   products of the dots, recombined products, and the sign decision,
//   which is the output register.
//   Each stage advances when it is empty or the stage after it advances, so
//   a stall at out_ready fills empty stages first and then drops in_ready;
//   nothing is lost or repeated. Up to five words can be in flight.
//   Reset (rst_n low, synchronous) empties the pipeline; the block has no
//   configuration and no state carried between words.
// ----------------------------------------------------------------------------
module point_in_triangle_test (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pit_pkg::coord_t in_a_x,
  input  pit_pkg::coord_t in_a_y,
  input  pit_pkg::coord_t in_a_z,
  input  pit_pkg::coord_t in_b_x,
  input  pit_pkg::coord_t in_b_y,
  input  pit_pkg::coord_t in_b_z,
  input  pit_pkg::coord_t in_c_x,
  input  pit_pkg::coord_t in_c_y,
  input  pit_pkg::coord_t in_c_z,
  input  pit_pkg::coord_t in_p_x,
  input  pit_pkg::coord_t in_p_y,
  input  pit_pkg::coord_t in_p_z,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_inside_res
);

  logic [pit_pkg::NSTAGE-1:0] vld_r;
  logic [pit_pkg::NSTAGE-1:0] vld_nxt;
  logic [pit_pkg::NSTAGE-1:0] adv;
  pit_pkg::pit_cross_en_t     cross_en;
  pit_pkg::pit_dot_en_t       dot_en;
  pit_pkg::point_t            pt_a;
  pit_pkg::point_t            pt_b;
  pit_pkg::point_t            pt_c;
  pit_pkg::point_t            pt_p;
  pit_pkg::cross_t            nrm [3];
  pit_pkg::cross_t            crs [3][3];

  // stage i loads when it is empty or its word moves on
  always_comb begin
    adv[pit_pkg::NSTAGE-1] = !vld_r[pit_pkg::NSTAGE-1] || out_ready;
    for (int i = pit_pkg::NSTAGE - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  always_comb begin
    vld_nxt[0] = adv[0] ? in_valid : vld_r[0];
    for (int i = 1; i < pit_pkg::NSTAGE; i++) begin
      vld_nxt[i] = adv[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready       = adv[0];
  assign out_valid      = vld_r[pit_pkg::NSTAGE-1];

  assign cross_en.s1 = adv[0];
  assign cross_en.s2 = adv[1];
  assign dot_en.s3   = adv[2];
  assign dot_en.s4   = adv[3];
  assign dot_en.s5   = adv[4];

  assign pt_a = '{x: in_a_x, y: in_a_y, z: in_a_z};
  assign pt_b = '{x: in_b_x, y: in_b_y, z: in_b_z};
  assign pt_c = '{x: in_c_x, y: in_c_y, z: in_c_z};
  assign pt_p = '{x: in_p_x, y: in_p_y, z: in_p_z};

  pit_cross u_cross (
    .clk  (clk),
    .en   (cross_en),
    .pt_a (pt_a),
    .pt_b (pt_b),
    .pt_c (pt_c),
    .pt_p (pt_p),
    .n_o  (nrm),
    .c_o  (crs)
  );

  pit_dot u_dot (
    .clk      (clk),
    .en       (dot_en),
    .n_i      (nrm),
    .c_i      (crs),
    .inside_o (out_inside_res)
  );

`ifndef SYNTHESIS
  // a full pipeline with a stalled receiver takes no new word
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r == '1 && !out_ready) |-> !in_ready)
    else $error("word accepted into a full stalled pipeline");

  // an accepted word occupies the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted word missing from first stage");

  // a word never waits in front of an empty output register
  a_no_bubble_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[pit_pkg::NSTAGE-2] && !vld_r[pit_pkg::NSTAGE-1]) |=> out_valid)
    else $error("word held back from empty output stage");

  // an output word leaves only through a handshake
  a_out_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_inside_res)))
    else $error("stalled result changed or dropped");
`endif

endmodule
